// ----- rtl/i2cm_pkg.sv -----
// Shared types and constants for the I2C master byte sequencer.
`default_nettype none
package i2cm_pkg;

   localparam int unsigned BITS_PER_BYTE = 8;
   localparam logic [15:0] DELAY_RESET   = 16'd500;

   // Command codes carried in the kind field
   typedef enum logic [2:0] {
      CMD_TICK  = 3'd0,
      CMD_START = 3'd1,
      CMD_STOP  = 3'd2,
      CMD_WRITE = 3'd3,
      CMD_READ  = 3'd4
   } cmd_type;

   // Bus segment within one command
   typedef enum logic [3:0] {
      PH_IDLE = 4'd0,
      PH_SEG1 = 4'd1,
      PH_SEG2 = 4'd2,
      PH_SEG3 = 4'd3,
      PH_SEG4 = 4'd4
   } phase_type;

   typedef struct packed {
      phase_type   phase;
      cmd_type     command_kind;
      logic [15:0] delay_count;
      logic [3:0]  bit_index;
      logic [7:0]  shift_reg;
      logic [7:0]  rx_reg;
      logic        ack_flag;
      logic        scl_reg;
      logic        sda_reg;
      logic        ack_out_reg;
   } state_type;

   typedef struct packed {
      logic       scl_level;
      logic       sda_level;
      logic       busy_res;
      logic       done_res;
      logic [7:0] rx_byte;
      logic       ack_received;
   } rsp_data_type;

endpackage
`default_nettype wire

// ----- rtl/i2cm_if.sv -----
// Channel interfaces: command input, result output and delay register write.
`default_nettype none
interface i2cm_req_if;
   logic       valid;
   logic       ready;
   logic [2:0] kind;
   logic [7:0] tx_byte;
   logic       ack_to_send;
   logic       sda_in;

   modport source (output valid, kind, tx_byte, ack_to_send, sda_in, input ready);
   modport sink   (input valid, kind, tx_byte, ack_to_send, sda_in, output ready);
endinterface

interface i2cm_rsp_if;
   logic       valid;
   logic       ready;
   logic       scl_level;
   logic       sda_level;
   logic       busy_res;
   logic       done_res;
   logic [7:0] rx_byte;
   logic       ack_received;

   modport source (output valid, scl_level, sda_level, busy_res, done_res, rx_byte,
                   ack_received, input ready);
   modport sink   (input valid, scl_level, sda_level, busy_res, done_res, rx_byte,
                   ack_received, output ready);
endinterface

interface i2cm_csr_if;
   logic        valid;
   logic        ready;
   logic [15:0] data;

   modport source (output valid, data, input ready);
   modport sink   (input valid, data, output ready);
endinterface
`default_nettype wire

// ----- rtl/i2cm_step.sv -----
// Next-state logic for one clock tick of the byte sequencer.
`default_nettype none
module i2cm_step (
   input  i2cm_pkg::state_type st,
   input  logic [2:0]          kind,
   input  logic [7:0]          tx_byte,
   input  logic                ack_to_send,
   input  logic                sda_in,
   input  logic [15:0]         delay_ticks,
   output i2cm_pkg::state_type nx,
   output logic                done
);
   import i2cm_pkg::*;

   logic [15:0] seg_last;
   logic [3:0]  bit_next;
   logic [7:0]  shift_next;

   // Enter a segment: set its line levels and load the hold count
   function automatic state_type enter_seg(state_type s, phase_type p, logic [15:0] cnt);
      state_type r;
      r = s;
      r.phase = p;
      r.delay_count = cnt;
      unique case (s.command_kind)
         CMD_START: begin
            if (p == PH_SEG2) r.sda_reg = 1'b1;
            else if (p == PH_SEG3) r.scl_reg = 1'b1;
            else if (p == PH_SEG4) r.sda_reg = 1'b0;
         end
         CMD_STOP: begin
            if (p == PH_SEG1) r.sda_reg = 1'b0;
            else if (p == PH_SEG2) r.scl_reg = 1'b1;
         end
         default: begin
            if (p == PH_SEG1) begin
               r.scl_reg = 1'b0;
               r.sda_reg = (s.command_kind == CMD_WRITE) ? s.shift_reg[7] : 1'b1;
            end else if (p == PH_SEG3) begin
               r.scl_reg = 1'b0;
               r.sda_reg = (s.command_kind == CMD_WRITE) ? 1'b1 : ~s.ack_out_reg;
            end else begin
               r.scl_reg = 1'b1;
            end
         end
      endcase
      return r;
   endfunction

   // A delay of zero acts as one tick per segment
   assign seg_last   = (delay_ticks == 16'd0) ? 16'd0 : delay_ticks - 16'd1;
   assign bit_next   = st.bit_index + 4'd1;
   assign shift_next = (st.command_kind == CMD_READ) ? {st.shift_reg[6:0], sda_in}
                                                     : {st.shift_reg[6:0], 1'b0};

   always_comb begin
      state_type t;
      t    = st;
      nx   = st;
      done = 1'b0;
      if (st.phase == PH_IDLE) begin
         // Launch a command; other kinds leave the block idle
         if (kind == CMD_START || kind == CMD_STOP || kind == CMD_WRITE ||
             kind == CMD_READ) begin
            t.command_kind = cmd_type'(kind);
            t.bit_index    = 4'd0;
            t.shift_reg    = (kind == CMD_WRITE) ? tx_byte : 8'd0;
            t.ack_out_reg  = ack_to_send;
            nx = enter_seg(t, PH_SEG1, seg_last);
         end
      end else if (st.delay_count != 16'd0) begin
         // Hold the current segment
         nx.delay_count = st.delay_count - 16'd1;
      end else begin
         // Segment over: advance or complete
         unique case (st.command_kind)
            CMD_START: begin
               if (st.phase != PH_SEG4) begin
                  nx = enter_seg(st, phase_type'(st.phase + 4'd1), seg_last);
               end else begin
                  nx.scl_reg = 1'b0;
                  done = 1'b1;
               end
            end
            CMD_STOP: begin
               if (st.phase == PH_SEG1) begin
                  nx = enter_seg(st, PH_SEG2, seg_last);
               end else begin
                  nx.sda_reg = 1'b1;
                  done = 1'b1;
               end
            end
            default: begin
               if (st.phase == PH_SEG1) begin
                  nx = enter_seg(st, PH_SEG2, seg_last);
               end else if (st.phase == PH_SEG2) begin
                  t.shift_reg = shift_next;
                  t.bit_index = bit_next;
                  nx = enter_seg(t, bit_next[3] ? PH_SEG3 : PH_SEG1, seg_last);
               end else if (st.phase == PH_SEG3) begin
                  nx = enter_seg(st, PH_SEG4, seg_last);
               end else begin
                  if (st.command_kind == CMD_WRITE) nx.ack_flag = ~sda_in;
                  else nx.rx_reg = st.shift_reg;
                  nx.scl_reg = 1'b0;
                  done = 1'b1;
               end
            end
         endcase
         if (done) begin
            nx.phase       = PH_IDLE;
            nx.delay_count = 16'd0;
         end
      end
   end

endmodule
`default_nettype wire

// ----- rtl/i2cm_rsp_reg.sv -----
// Result output register: holds one transaction until the sink takes it.
`default_nettype none
module i2cm_rsp_reg (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   load,
   input  i2cm_pkg::rsp_data_type data_in,
   output logic                   free,
   i2cm_rsp_if.source             rsp
);
   import i2cm_pkg::*;

   logic         valid_ff;
   logic         valid_in;
   rsp_data_type data_ff;

   // Room for a new result when empty or when the held one leaves now
   assign free     = !valid_ff || rsp.ready;
   assign valid_in = load || (valid_ff && !rsp.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         data_ff <= data_in;
      end
   end

   assign rsp.valid        = valid_ff;
   assign rsp.scl_level    = data_ff.scl_level;
   assign rsp.sda_level    = data_ff.sda_level;
   assign rsp.busy_res     = data_ff.busy_res;
   assign rsp.done_res     = data_ff.done_res;
   assign rsp.rx_byte      = data_ff.rx_byte;
   assign rsp.ack_received = data_ff.ack_received;

endmodule
`default_nettype wire

// ----- rtl/i2c_master_byte_sequencer.sv -----
// Top level of the I2C master byte sequencer.
//
//   channel  dir  handshake           payload
//   req      in   req.valid/ready     kind, tx_byte, ack_to_send, sda_in
//   rsp      out  rsp.valid/ready     scl_level, sda_level, busy_res, done_res,
//                                     rx_byte, ack_received
//   csr      in   csr.valid/ready     data (delay_ticks)
//
// One transaction is one bus tick: its result shows in the output register in the
// cycle after it is accepted, so a tick can follow every cycle while no result is stalled.
// The sequencer state register and the output register lie on that path.
// Reset clears the sequencer to idle with both lines released, delay 500.
// A stalled result holds the input off; the next tick is taken in the cycle
// the held result leaves. Delay writes are always accepted.
`default_nettype none
module i2c_master_byte_sequencer (
   input  logic       clock,
   input  logic       reset,
   i2cm_req_if.sink   req,
   i2cm_rsp_if.source rsp,
   i2cm_csr_if.sink   csr
);
   import i2cm_pkg::*;

   state_type    st_ff;
   state_type    st_in;
   logic [15:0]  delay_ticks_ff;
   logic         done;
   logic         free;
   logic         accept;
   rsp_data_type rsp_data;

   assign req.ready = free;
   assign accept    = req.valid && free;
   assign csr.ready = 1'b1;

   // Hold the delay register
   always_ff @(posedge clock) begin
      if (reset) begin
         delay_ticks_ff <= DELAY_RESET;
      end else if (csr.valid) begin
         delay_ticks_ff <= csr.data;
      end
   end

   i2cm_step u_step (
      .st          (st_ff),
      .kind        (req.kind),
      .tx_byte     (req.tx_byte),
      .ack_to_send (req.ack_to_send),
      .sda_in      (req.sda_in),
      .delay_ticks (delay_ticks_ff),
      .nx          (st_in),
      .done        (done)
   );

   // Advance the sequencer state on each accepted tick
   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= '{phase: PH_IDLE, command_kind: CMD_TICK, delay_count: 16'd0,
                    bit_index: 4'd0, shift_reg: 8'd0, rx_reg: 8'd0, ack_flag: 1'b0,
                    scl_reg: 1'b1, sda_reg: 1'b1, ack_out_reg: 1'b0};
      end else if (accept) begin
         st_ff <= st_in;
      end
   end

   // Build the result from the updated state
   assign rsp_data = '{scl_level: st_in.scl_reg, sda_level: st_in.sda_reg,
                       busy_res: (st_in.phase != PH_IDLE), done_res: done,
                       rx_byte: st_in.rx_reg, ack_received: st_in.ack_flag};

   i2cm_rsp_reg u_rsp_reg (
      .clock   (clock),
      .reset   (reset),
      .load    (accept),
      .data_in (rsp_data),
      .free    (free),
      .rsp     (rsp)
   );

`ifndef SYNTH
   a_done_not_busy: assert property (@(posedge clock) disable iff (reset)
      rsp.valid |-> !(rsp.done_res && rsp.busy_res))
      else $error("result reports done while still busy");

   a_idle_count_zero: assert property (@(posedge clock) disable iff (reset)
      (st_ff.phase == PH_IDLE) |-> (st_ff.delay_count == 16'd0))
      else $error("hold count left running while idle");

   a_bit_index_range: assert property (@(posedge clock) disable iff (reset)
      st_ff.bit_index <= 4'd8)
      else $error("bit index beyond one byte");

   a_tick_stays_idle: assert property (@(posedge clock) disable iff (reset)
      (accept && st_ff.phase == PH_IDLE && req.kind == CMD_TICK)
      |=> (st_ff.phase == PH_IDLE))
      else $error("plain tick started a command");
`endif

endmodule
`default_nettype wire
